FILE: rtl/gda_pkg.sv
// Shared types, constants and calendar helper functions for the Gregorian date unit.
// Used by every module of the block; it depends on nothing else.
package gda_pkg;

    localparam int DAY_W          = 5;
    localparam int MONTH_W        = 4;
    localparam int YEAR_W         = 14;
    localparam int RES_W          = 9;
    localparam int VALUE_W        = 16;
    localparam int MUL_W          = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int S_DATA_W       = 64;
    localparam int S_USER_W       = 3;
    localparam int M_DATA_W       = 48;
    localparam int M_USER_W       = 2;

    localparam int YEAR_MOD = 400;
    localparam logic [YEAR_W-1:0] YEAR_MAX       = YEAR_W'((1 << YEAR_W) - 1);
    localparam logic [YEAR_W-1:0] YEAR_FLOOR_RST = YEAR_W'(1);
    localparam logic [RES_W-1:0]  RES_LAST       = RES_W'(YEAR_MOD - 1);
    localparam logic [RES_W-1:0]  YEAR_WRAP_RES  = RES_W'(((1 << YEAR_W) - 1) % YEAR_MOD);

    // Reciprocal multipliers; each quotient is low by at most one and gets one correction.
    localparam logic [MUL_W-1:0] RECIP_400 = MUL_W'(2621);
    localparam int               SHIFT_400 = 20;
    localparam logic [MUL_W-1:0] RECIP_100 = MUL_W'(5242);
    localparam int               SHIFT_100 = 19;
    localparam logic [MUL_W-1:0] RECIP_7   = MUL_W'(18724);
    localparam int               SHIFT_7   = 17;

    typedef enum logic [2:0] {
        OP_VALIDATE = 3'd0,
        OP_NEXT     = 3'd1,
        OP_PREV     = 3'd2,
        OP_ADD      = 3'd3,
        OP_SUB      = 3'd4,
        OP_BETWEEN  = 3'd5,
        OP_WEEKDAY  = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_SPAN    = 2'd2
    } status_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    // A date together with its year taken modulo 400.
    typedef struct packed {
        date_t            date;
        logic [RES_W-1:0] res;
    } step_t;

    function automatic logic is_leap(input logic [RES_W-1:0] res);
        return (res[1:0] == 2'b00) && (res != RES_W'(100)) && (res != RES_W'(200))
            && (res != RES_W'(300));
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        case (m)
            4'd2: begin
                return leap ? DAY_W'(29) : DAY_W'(28);
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                return DAY_W'(30);
            end
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
                return DAY_W'(31);
            end
            default: begin
                return '0;
            end
        endcase
    endfunction

    // Month term of the weekday sum: (31 * shifted month) / 12.
    function automatic logic [DAY_W-1:0] wd_month_offset(input logic [MONTH_W-1:0] m);
        case (m)
            4'd1:    return DAY_W'(28);
            4'd2:    return DAY_W'(31);
            4'd3:    return DAY_W'(2);
            4'd4:    return DAY_W'(5);
            4'd5:    return DAY_W'(7);
            4'd6:    return DAY_W'(10);
            4'd7:    return DAY_W'(12);
            4'd8:    return DAY_W'(15);
            4'd9:    return DAY_W'(18);
            4'd10:   return DAY_W'(20);
            4'd11:   return DAY_W'(23);
            4'd12:   return DAY_W'(25);
            default: return '0;
        endcase
    endfunction

endpackage

FILE: rtl/gda_mul.sv
// Shared multiplier with a registered product, used for the reciprocal divisions.
// Depends on gda_pkg for the operand width.
module gda_mul (
    input  logic                              aclk,
    input  logic [gda_pkg::MUL_W-1:0]         mul_a,
    input  logic [gda_pkg::MUL_W-1:0]         mul_b,
    output logic [2*gda_pkg::MUL_W-1:0]       prod
);

    logic [2*gda_pkg::MUL_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/gda_date_step.sv
// Date stepper: checks a date and gives the day after or before it.
// Depends on gda_pkg for the date types and calendar functions.
module gda_date_step (
    input  gda_pkg::step_t                  cur,
    input  logic                            fwd,
    input  logic [gda_pkg::YEAR_W-1:0]      year_floor,
    output gda_pkg::step_t                  nxt,
    output logic                            cur_valid
);

    logic                          leap;
    logic [gda_pkg::DAY_W-1:0]     dim;
    logic [gda_pkg::DAY_W-1:0]     prev_dim;
    logic [gda_pkg::MONTH_W-1:0]   prev_month;

    assign leap       = gda_pkg::is_leap(cur.res);
    assign dim        = gda_pkg::month_days(cur.date.month, leap);
    assign prev_month = cur.date.month - gda_pkg::MONTH_W'(1);
    assign prev_dim   = gda_pkg::month_days(prev_month, leap);

    assign cur_valid = (cur.date.year >= year_floor)
                    && (cur.date.month >= gda_pkg::MONTH_W'(1))
                    && (cur.date.month <= gda_pkg::MONTH_W'(12))
                    && (cur.date.day >= gda_pkg::DAY_W'(1))
                    && (cur.date.day <= dim);

    always_comb begin
        nxt = cur;
        if (cur_valid) begin
            if (fwd) begin
                if (cur.date.day == dim) begin
                    nxt.date.day = gda_pkg::DAY_W'(1);
                    if (cur.date.month == gda_pkg::MONTH_W'(12)) begin
                        nxt.date.month = gda_pkg::MONTH_W'(1);
                        nxt.date.year  = cur.date.year + gda_pkg::YEAR_W'(1);
                        if (cur.date.year == gda_pkg::YEAR_MAX) begin
                            nxt.res = '0;
                        end else if (cur.res == gda_pkg::RES_LAST) begin
                            nxt.res = '0;
                        end else begin
                            nxt.res = cur.res + gda_pkg::RES_W'(1);
                        end
                    end else begin
                        nxt.date.month = cur.date.month + gda_pkg::MONTH_W'(1);
                    end
                end else begin
                    nxt.date.day = cur.date.day + gda_pkg::DAY_W'(1);
                end
            end else begin
                if (cur.date.day == gda_pkg::DAY_W'(1)) begin
                    if (cur.date.month == gda_pkg::MONTH_W'(1)) begin
                        nxt.date.month = gda_pkg::MONTH_W'(12);
                        nxt.date.day   = gda_pkg::DAY_W'(31);
                        nxt.date.year  = cur.date.year - gda_pkg::YEAR_W'(1);
                        if (cur.date.year == '0) begin
                            nxt.res = gda_pkg::YEAR_WRAP_RES;
                        end else if (cur.res == '0) begin
                            nxt.res = gda_pkg::RES_LAST;
                        end else begin
                            nxt.res = cur.res - gda_pkg::RES_W'(1);
                        end
                    end else begin
                        nxt.date.month = prev_month;
                        nxt.date.day   = prev_dim;
                    end
                end else begin
                    nxt.date.day = cur.date.day - gda_pkg::DAY_W'(1);
                end
            end
        end
    end

endmodule

FILE: rtl/gregorian_date_arithmetic_unit.sv
// Top level of the Gregorian date unit: request sequencer, stream ports and output register.
// Depends on gda_pkg, gda_date_step and gda_mul.
//
//   Port group     Direction  Handshake          Word contents
//   s_*            in         s_tvalid/s_tready  request: date, target date, day count, operation
//   m_*            out        m_tvalid/m_tready  result: date, value, status
//   cfg_*          in         cfg_we             lowest valid year write
//
// One word is taken at a time; s_tready is high only while the sequencer is idle. S_MUL and
// S_RES reduce the year modulo 400 on the shared multiplier, then S_DISP dispatches: validate
// and unused codes go straight to S_OUT, next and previous walk one day, add or subtract by N
// days walks N days, a span of S days walks forward counting S (S at most 2^COUNT_BITS - 1; a
// walk onto an invalid date ends early), weekday runs S_WD1 to S_WD5. The sequencer is idle again
// once the result is registered. A result meeting an unread one waits. Reset is synchronous.
module gregorian_date_arithmetic_unit #(
    parameter int COUNT_BITS = gda_pkg::COUNT_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // day, month, year, day2, month2, year2, day_count, zero fill
    input  logic [gda_pkg::S_DATA_W-1:0]      s_tdata,
    // req_type
    input  logic [gda_pkg::S_USER_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_day, out_month, out_year, out_value, zero fill
    output logic [gda_pkg::M_DATA_W-1:0]      m_tdata,
    // status
    output logic [gda_pkg::M_USER_W-1:0]      m_tuser,
    input  logic                              cfg_we,
    input  logic [gda_pkg::YEAR_W-1:0]        cfg_wdata
);

    localparam int CNT_W = (COUNT_BITS > gda_pkg::VALUE_W) ? COUNT_BITS : gda_pkg::VALUE_W;
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'((64'd1 << COUNT_BITS) - 64'd1);
    localparam int YY_W = gda_pkg::YEAR_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_RES,
        S_DISP,
        S_WALK,
        S_WD1,
        S_WD2,
        S_WD3,
        S_WD4,
        S_WD5,
        S_OUT
    } state_t;

    state_t                              state_reg, state_next;
    gda_pkg::op_t                        op_reg, op_next;
    gda_pkg::date_t                      first_reg, first_next;
    gda_pkg::date_t                      target_reg, target_next;
    gda_pkg::step_t                      work_reg, work_next;
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic [gda_pkg::VALUE_W-1:0]         value_reg, value_next;
    gda_pkg::status_t                    status_reg, status_next;
    logic [gda_pkg::VALUE_W-1:0]         tmp_reg, tmp_next;
    logic [gda_pkg::YEAR_W-1:0]          year_floor_reg, year_floor_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    gda_pkg::date_t                      m_date_reg, m_date_next;
    logic [gda_pkg::VALUE_W-1:0]         m_value_reg, m_value_next;
    gda_pkg::status_t                    m_status_reg, m_status_next;

    gda_pkg::step_t                      step_nxt;
    logic                                step_valid;
    logic                                step_fwd;
    logic [gda_pkg::MUL_W-1:0]           mul_a;
    logic [gda_pkg::MUL_W-1:0]           mul_b;
    logic [2*gda_pkg::MUL_W-1:0]         prod;

    logic [YY_W-1:0]                     yy;
    logic [5:0]                          q400;
    logic [YY_W-1:0]                     r400;
    logic [7:0]                          q100;
    logic [YY_W-1:0]                     r100;
    logic [12:0]                         q7;
    logic [gda_pkg::VALUE_W-1:0]         r7;
    logic [gda_pkg::VALUE_W-1:0]         wd_sum;

    assign step_fwd = !((op_reg == gda_pkg::OP_PREV) || (op_reg == gda_pkg::OP_SUB));

    gda_date_step u_step (
        .cur        (work_reg),
        .fwd        (step_fwd),
        .year_floor (year_floor_reg),
        .nxt        (step_nxt),
        .cur_valid  (step_valid)
    );

    gda_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    always_comb begin
        yy = YY_W'(work_reg.date.year) + YY_W'(gda_pkg::YEAR_MOD);
        if (work_reg.date.month <= gda_pkg::MONTH_W'(2)) begin
            yy = yy - YY_W'(1);
        end

        q400 = 6'(prod >> gda_pkg::SHIFT_400);
        r400 = YY_W'(work_reg.date.year) - YY_W'(q400) * YY_W'(gda_pkg::YEAR_MOD);
        if (r400 >= YY_W'(gda_pkg::YEAR_MOD)) begin
            r400 = r400 - YY_W'(gda_pkg::YEAR_MOD);
        end

        q100 = 8'(prod >> gda_pkg::SHIFT_100);
        r100 = yy - YY_W'(q100) * YY_W'(100);
        if (r100 >= YY_W'(100)) begin
            q100 = q100 + 8'd1;
        end

        wd_sum = gda_pkg::VALUE_W'(work_reg.date.day) + gda_pkg::VALUE_W'(yy)
               + gda_pkg::VALUE_W'(yy >> 2) - tmp_reg + (tmp_reg >> 2)
               + gda_pkg::VALUE_W'(gda_pkg::wd_month_offset(work_reg.date.month));

        q7 = 13'(prod >> gda_pkg::SHIFT_7);
        r7 = tmp_reg - gda_pkg::VALUE_W'(q7) * gda_pkg::VALUE_W'(7);
        if (r7 >= gda_pkg::VALUE_W'(7)) begin
            r7 = r7 - gda_pkg::VALUE_W'(7);
        end
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        first_next      = first_reg;
        target_next     = target_reg;
        work_next       = work_reg;
        cnt_next        = cnt_reg;
        value_next      = value_reg;
        status_next     = status_reg;
        tmp_next        = tmp_reg;
        year_floor_next = cfg_we ? cfg_wdata : year_floor_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_date_next     = m_date_reg;
        m_value_next    = m_value_reg;
        m_status_next   = m_status_reg;
        mul_a           = '0;
        mul_b           = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next            = gda_pkg::op_t'(s_tuser[2:0]);
                    first_next.day     = s_tdata[4:0];
                    first_next.month   = s_tdata[8:5];
                    first_next.year    = s_tdata[22:9];
                    target_next.day    = s_tdata[27:23];
                    target_next.month  = s_tdata[31:28];
                    target_next.year   = s_tdata[45:32];
                    cnt_next           = CNT_W'(s_tdata[61:46]);
                    work_next.date.day   = s_tdata[4:0];
                    work_next.date.month = s_tdata[8:5];
                    work_next.date.year  = s_tdata[22:9];
                    state_next         = S_MUL;
                end
            end
            S_MUL: begin
                mul_a      = gda_pkg::MUL_W'(work_reg.date.year);
                mul_b      = gda_pkg::RECIP_400;
                state_next = S_RES;
            end
            S_RES: begin
                work_next.res = r400[gda_pkg::RES_W-1:0];
                state_next    = S_DISP;
            end
            S_DISP: begin
                value_next  = '0;
                status_next = gda_pkg::ST_OK;
                state_next  = S_OUT;
                case (op_reg)
                    gda_pkg::OP_VALIDATE: begin
                        value_next  = gda_pkg::VALUE_W'(step_valid);
                        status_next = step_valid ? gda_pkg::ST_OK : gda_pkg::ST_INVALID;
                    end
                    gda_pkg::OP_NEXT, gda_pkg::OP_PREV: begin
                        cnt_next   = CNT_W'(1);
                        state_next = S_WALK;
                    end
                    gda_pkg::OP_ADD, gda_pkg::OP_SUB: begin
                        state_next = S_WALK;
                    end
                    gda_pkg::OP_BETWEEN: begin
                        if (step_valid) begin
                            cnt_next   = '0;
                            state_next = S_WALK;
                        end else begin
                            status_next = gda_pkg::ST_INVALID;
                        end
                    end
                    gda_pkg::OP_WEEKDAY: begin
                        if (step_valid) begin
                            state_next = S_WD1;
                        end else begin
                            status_next = gda_pkg::ST_INVALID;
                        end
                    end
                    default: begin
                        status_next = gda_pkg::ST_OK;
                    end
                endcase
            end
            S_WALK: begin
                if (op_reg == gda_pkg::OP_BETWEEN) begin
                    if (work_reg.date == target_reg) begin
                        value_next  = cnt_reg[gda_pkg::VALUE_W-1:0];
                        status_next = gda_pkg::ST_OK;
                        state_next  = S_OUT;
                    end else if ((cnt_reg == LIMIT) || !step_valid) begin
                        value_next  = LIMIT[gda_pkg::VALUE_W-1:0];
                        status_next = gda_pkg::ST_SPAN;
                        state_next  = S_OUT;
                    end else begin
                        work_next = step_nxt;
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                end else begin
                    if ((cnt_reg == '0) || !step_valid) begin
                        status_next = step_valid ? gda_pkg::ST_OK : gda_pkg::ST_INVALID;
                        state_next  = S_OUT;
                    end else begin
                        work_next = step_nxt;
                        cnt_next  = cnt_reg - CNT_W'(1);
                    end
                end
            end
            S_WD1: begin
                mul_a      = gda_pkg::MUL_W'(yy);
                mul_b      = gda_pkg::RECIP_100;
                state_next = S_WD2;
            end
            S_WD2: begin
                tmp_next   = gda_pkg::VALUE_W'(q100);
                state_next = S_WD3;
            end
            S_WD3: begin
                tmp_next   = wd_sum;
                state_next = S_WD4;
            end
            S_WD4: begin
                mul_a      = tmp_reg;
                mul_b      = gda_pkg::RECIP_7;
                state_next = S_WD5;
            end
            S_WD5: begin
                value_next  = r7;
                status_next = gda_pkg::ST_OK;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_date_next   = (op_reg == gda_pkg::OP_BETWEEN) ? first_reg : work_reg.date;
                    m_value_next  = value_reg;
                    m_status_next = status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            year_floor_reg <= gda_pkg::YEAR_FLOOR_RST;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            year_floor_reg <= year_floor_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        op_reg       <= op_next;
        first_reg    <= first_next;
        target_reg   <= target_next;
        work_reg     <= work_next;
        cnt_reg      <= cnt_next;
        value_reg    <= value_next;
        status_reg   <= status_next;
        tmp_reg      <= tmp_next;
        m_date_reg   <= m_date_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {9'b0, m_value_reg, m_date_reg.year, m_date_reg.month, m_date_reg.day};
    assign m_tuser  = m_status_reg;

endmodule

FILE: verif/gregorian_date_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for gregorian_date_arithmetic_unit: calendar corner cases first,
// then random requests under several lowest-year settings and handshake stall patterns.
// Depends on gda_pkg and the RTL of the block; a small class predicts and checks results.
module gregorian_date_arithmetic_unit_tb;

    localparam logic [2:0]  OP_UNUSED  = 3'd7;
    localparam int unsigned SPAN_LIMIT = (1 << gda_pkg::COUNT_BITS_DEF) - 1;
    localparam int unsigned YEAR_SPAN  = 1 << gda_pkg::YEAR_W;

    typedef struct {
        logic [2:0]                  op;
        gda_pkg::date_t              first;
        gda_pkg::date_t              target;
        logic [gda_pkg::VALUE_W-1:0] count;
    } date_request_t;

    typedef struct {
        gda_pkg::date_t              dt;
        logic [gda_pkg::VALUE_W-1:0] value;
        gda_pkg::status_t            st;
    } date_result_t;

    class calendar_checker;
        logic [gda_pkg::YEAR_W-1:0] year_floor;
        date_result_t               awaited_results[$];
        int                         mismatches;

        function new();
            year_floor = gda_pkg::YEAR_FLOOR_RST;
            mismatches = 0;
        endfunction

        function bit is_leap_year(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int unsigned days_in_month(int unsigned m, int unsigned y);
            if (m == 2 && is_leap_year(y)) begin
                return 29;
            end
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return 28;
                default:               return 0;
            endcase
        endfunction

        function bit date_ok(gda_pkg::date_t dt);
            return dt.year >= year_floor && dt.month >= 4'd1 && dt.month <= 4'd12
                && dt.day >= 5'd1 && 32'(dt.day) <= days_in_month(dt.month, dt.year);
        endfunction

        function gda_pkg::date_t advance_day(gda_pkg::date_t dt);
            gda_pkg::date_t nx;
            nx = dt;
            if (!date_ok(dt)) begin
                return dt;
            end
            if (32'(dt.day) == days_in_month(dt.month, dt.year)) begin
                nx.day = 5'd1;
                if (dt.month == 4'd12) begin
                    nx.month = 4'd1;
                    nx.year  = dt.year + 1'b1;
                end else begin
                    nx.month = dt.month + 1'b1;
                end
            end else begin
                nx.day = dt.day + 1'b1;
            end
            return nx;
        endfunction

        function gda_pkg::date_t retreat_day(gda_pkg::date_t dt);
            gda_pkg::date_t nx;
            nx = dt;
            if (!date_ok(dt)) begin
                return dt;
            end
            if (dt.day == 5'd1) begin
                if (dt.month == 4'd1) begin
                    nx.month = 4'd12;
                    nx.year  = dt.year - 1'b1;
                end else begin
                    nx.month = dt.month - 1'b1;
                end
                nx.day = gda_pkg::DAY_W'(days_in_month(nx.month, nx.year));
            end else begin
                nx.day = dt.day - 1'b1;
            end
            return nx;
        endfunction

        function int unsigned days_before_year(int unsigned y);
            return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        endfunction

        function int unsigned day_number(gda_pkg::date_t dt);
            int unsigned s;
            s = days_before_year(dt.year);
            for (int unsigned i = 1; i < 32'(dt.month); i++) begin
                s += days_in_month(i, dt.year);
            end
            return s + 32'(dt.day) - 1;
        endfunction

        function int unsigned day_of_week(gda_pkg::date_t dt);
            int unsigned a, yy, mm;
            a  = (14 - 32'(dt.month)) / 12;
            yy = 32'(dt.year) + 400 - a;
            mm = 32'(dt.month) + 12 * a - 2;
            return (32'(dt.day) + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
        endfunction

        function date_result_t predict_date_result(date_request_t rq);
            date_result_t   r;
            gda_pkg::date_t dt;
            bit             ok, fwd, t_ok, reach;
            int unsigned    n, s1, span_days;
            dt      = rq.first;
            ok      = date_ok(dt);
            r.value = '0;
            r.st    = gda_pkg::ST_OK;
            case (rq.op)
                gda_pkg::OP_VALIDATE: begin
                    r.value = ok ? gda_pkg::VALUE_W'(1) : gda_pkg::VALUE_W'(0);
                    r.st    = ok ? gda_pkg::ST_OK : gda_pkg::ST_INVALID;
                end
                gda_pkg::OP_NEXT, gda_pkg::OP_PREV, gda_pkg::OP_ADD, gda_pkg::OP_SUB: begin
                    n   = (rq.op == gda_pkg::OP_NEXT || rq.op == gda_pkg::OP_PREV)
                        ? 1 : 32'(rq.count);
                    fwd = (rq.op == gda_pkg::OP_NEXT || rq.op == gda_pkg::OP_ADD);
                    repeat (n) begin
                        dt = fwd ? advance_day(dt) : retreat_day(dt);
                    end
                    r.st = (ok && date_ok(dt)) ? gda_pkg::ST_OK : gda_pkg::ST_INVALID;
                end
                gda_pkg::OP_BETWEEN: begin
                    if (!ok) begin
                        r.st = gda_pkg::ST_INVALID;
                    end else begin
                        t_ok      = date_ok(rq.target);
                        s1        = day_number(dt);
                        reach     = 1'b1;
                        span_days = 0;
                        if (t_ok && day_number(rq.target) >= s1) begin
                            span_days = day_number(rq.target) - s1;
                        end else if (t_ok && year_floor == '0) begin
                            span_days = days_before_year(YEAR_SPAN) - s1
                                      + day_number(rq.target);
                        end else if (year_floor != '0 && rq.target.day == 5'd1
                                     && rq.target.month == 4'd1 && rq.target.year == '0) begin
                            span_days = days_before_year(YEAR_SPAN) - s1;
                        end else begin
                            reach = 1'b0;
                        end
                        if (reach && span_days <= SPAN_LIMIT) begin
                            r.value = gda_pkg::VALUE_W'(span_days);
                        end else begin
                            r.value = gda_pkg::VALUE_W'(SPAN_LIMIT);
                            r.st    = gda_pkg::ST_SPAN;
                        end
                    end
                end
                gda_pkg::OP_WEEKDAY: begin
                    if (ok) begin
                        r.value = gda_pkg::VALUE_W'(day_of_week(dt));
                    end else begin
                        r.st = gda_pkg::ST_INVALID;
                    end
                end
                default: begin
                end
            endcase
            r.dt = dt;
            return r;
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        function int pending();
            return awaited_results.size();
        endfunction

        function void note_request(date_request_t rq);
            awaited_results.push_back(predict_date_result(rq));
        endfunction

        task check_word(logic [gda_pkg::M_DATA_W-1:0] data,
                        logic [gda_pkg::M_USER_W-1:0] user);
            date_result_t want;
            if (awaited_results.size() == 0) begin
                report($sformatf("result word %h with no request outstanding", data));
                return;
            end
            want = awaited_results.pop_front();
            if (data[4:0] !== want.dt.day) begin
                report($sformatf("out_day %0d, expected %0d", data[4:0], want.dt.day));
            end
            if (data[8:5] !== want.dt.month) begin
                report($sformatf("out_month %0d, expected %0d", data[8:5], want.dt.month));
            end
            if (data[22:9] !== want.dt.year) begin
                report($sformatf("out_year %0d, expected %0d", data[22:9], want.dt.year));
            end
            if (data[38:23] !== want.value) begin
                report($sformatf("out_value %0d, expected %0d", data[38:23], want.value));
            end
            if (user !== want.st) begin
                report($sformatf("status %0d, expected %0d", user, want.st));
            end
        endtask
    endclass

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [gda_pkg::S_DATA_W-1:0]    s_tdata   = '0;
    logic [gda_pkg::S_USER_W-1:0]    s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [gda_pkg::M_DATA_W-1:0]    m_tdata;
    logic [gda_pkg::M_USER_W-1:0]    m_tuser;
    logic                            cfg_we    = 1'b0;
    logic [gda_pkg::YEAR_W-1:0]      cfg_wdata = '0;

    int send_idle_pct = 9;
    int recv_idle_pct = 58;
    int long_walks_left = 4;

    calendar_checker tracker = new();

    gregorian_date_arithmetic_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("gregorian_date_arithmetic_unit_tb failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_word(m_tdata, m_tuser);
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic gda_pkg::date_t make_date(int unsigned d, int unsigned m,
                                                 int unsigned y);
        gda_pkg::date_t dt;
        dt.day   = gda_pkg::DAY_W'(d);
        dt.month = gda_pkg::MONTH_W'(m);
        dt.year  = gda_pkg::YEAR_W'(y);
        return dt;
    endfunction

    task automatic send_request(date_request_t rq);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.op;
        s_tdata  <= {2'b00, rq.count, rq.target.year, rq.target.month, rq.target.day,
                     rq.first.year, rq.first.month, rq.first.day};
        do @(posedge aclk); while (!s_tready);
        tracker.note_request(rq);
    endtask

    task automatic send_dates(logic [2:0] op, gda_pkg::date_t first, gda_pkg::date_t target,
                              int unsigned count);
        date_request_t rq;
        rq.op     = op;
        rq.first  = first;
        rq.target = target;
        rq.count  = gda_pkg::VALUE_W'(count);
        send_request(rq);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_year_floor(int unsigned v);
        cfg_we    <= 1'b1;
        cfg_wdata <= gda_pkg::YEAR_W'(v);
        @(posedge aclk);
        cfg_we <= 1'b0;
        tracker.year_floor = gda_pkg::YEAR_W'(v);
    endtask

    function automatic gda_pkg::date_t random_date();
        int unsigned y, m;
        if ($urandom_range(0, 99) < 15) begin
            return make_date($urandom_range(0, 31), $urandom_range(0, 15),
                             $urandom_range(0, 9999));
        end
        y = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 9999)
                                        : $urandom_range(tracker.year_floor, 9999);
        m = $urandom_range(1, 12);
        return make_date($urandom_range(1, tracker.days_in_month(m, y)), m, y);
    endfunction

    task automatic random_request(output date_request_t rq);
        rq.op     = ($urandom_range(0, 49) == 0) ? OP_UNUSED : 3'($urandom_range(0, 6));
        rq.first  = random_date();
        rq.target = make_date($urandom_range(0, 31), $urandom_range(0, 15),
                              $urandom_range(0, 9999));
        rq.count  = gda_pkg::VALUE_W'($urandom);
        if (rq.op == gda_pkg::OP_ADD || rq.op == gda_pkg::OP_SUB) begin
            if (long_walks_left > 0 && $urandom_range(0, 199) == 0) begin
                long_walks_left--;
                rq.count = gda_pkg::VALUE_W'($urandom_range(30000, 65535));
            end else begin
                rq.count = gda_pkg::VALUE_W'($urandom_range(0, 300));
            end
        end else if (rq.op == gda_pkg::OP_BETWEEN && tracker.date_ok(rq.first)) begin
            if (long_walks_left > 0 && $urandom_range(0, 99) == 0) begin
                long_walks_left--;
            end else begin
                rq.target = rq.first;
                repeat ($urandom_range(0, 300)) begin
                    rq.target = tracker.advance_day(rq.target);
                end
            end
        end
    endtask

    initial begin
        date_request_t  rq;
        gda_pkg::date_t none;
        none = make_date(31, 15, 9999);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_dates(gda_pkg::OP_VALIDATE, make_date(29, 2, 2000), none, 65535);
        send_dates(gda_pkg::OP_VALIDATE, make_date(29, 2, 1900), make_date(0, 0, 0), 0);
        send_dates(gda_pkg::OP_VALIDATE, make_date(0, 0, 0), none, 0);
        send_dates(gda_pkg::OP_VALIDATE, make_date(31, 15, 9999), none, 65535);
        send_dates(gda_pkg::OP_VALIDATE, make_date(1, 1, 0), none, 0);
        send_dates(gda_pkg::OP_NEXT, make_date(31, 12, 2023), none, 0);
        send_dates(gda_pkg::OP_NEXT, make_date(28, 2, 2024), none, 0);
        send_dates(gda_pkg::OP_PREV, make_date(1, 3, 2024), none, 0);
        send_dates(gda_pkg::OP_PREV, make_date(1, 1, 1), none, 0);
        send_dates(gda_pkg::OP_NEXT, make_date(31, 12, 16383), none, 0);
        send_dates(gda_pkg::OP_NEXT, make_date(30, 2, 2023), none, 0);
        send_dates(gda_pkg::OP_ADD, make_date(5, 5, 2023), none, 0);
        send_dates(gda_pkg::OP_ADD, make_date(1, 1, 2000), none, 65535);
        send_dates(gda_pkg::OP_SUB, make_date(31, 12, 9999), none, 65535);
        send_dates(gda_pkg::OP_SUB, make_date(10, 1, 1), none, 20);
        send_dates(gda_pkg::OP_BETWEEN, make_date(1, 1, 2023), make_date(31, 12, 2023), 0);
        send_dates(gda_pkg::OP_BETWEEN, make_date(15, 7, 1969), make_date(15, 7, 1969), 0);
        send_dates(gda_pkg::OP_BETWEEN, make_date(1, 6, 2023), make_date(1, 5, 2023), 0);
        send_dates(gda_pkg::OP_BETWEEN, make_date(1, 1, 2000), make_date(1, 1, 2200), 0);
        send_dates(gda_pkg::OP_BETWEEN, make_date(31, 4, 2023), make_date(1, 5, 2023), 0);
        send_dates(gda_pkg::OP_BETWEEN, make_date(20, 12, 16383), make_date(1, 1, 0), 0);
        send_dates(gda_pkg::OP_WEEKDAY, make_date(1, 1, 2000), none, 0);
        send_dates(gda_pkg::OP_WEEKDAY, make_date(1, 13, 2023), none, 0);
        send_dates(OP_UNUSED, make_date(17, 9, 1752), none, 12345);
        wait_for_results();

        write_year_floor(0);
        send_dates(gda_pkg::OP_PREV, make_date(1, 1, 0), none, 0);
        send_dates(gda_pkg::OP_BETWEEN, make_date(30, 12, 16383), make_date(2, 1, 0), 0);
        wait_for_results();

        for (int blk = 0; blk < 12; blk++) begin
            case (blk / 4)
                0: begin
                    send_idle_pct = 9;
                    recv_idle_pct = 58;
                end
                1: begin
                    send_idle_pct = 58;
                    recv_idle_pct = 9;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (blk % 4)
                0:       write_year_floor(9999);
                1:       write_year_floor($urandom_range(1, 9998));
                2:       write_year_floor(1);
                default: write_year_floor(0);
            endcase
            for (int i = 0; i < 84; i++) begin
                if ($urandom_range(0, 59) == 0) begin
                    wait_for_results();
                end
                random_request(rq);
                send_request(rq);
            end
            wait_for_results();
        end

        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("gregorian_date_arithmetic_unit_tb passed");
        end else begin
            $display("gregorian_date_arithmetic_unit_tb failed");
        end
        $finish;
    end

endmodule
